>>> hw/rtl/lmtp_pkg.sv
// Shared constants and controller/datapath interface types for the min-travel picker.
`timescale 1ns / 1ps

package lmtp_pkg;

    // Path costs are carried at a fixed width and saturate at all ones.
    localparam int COST_W = 19;
    localparam logic [COST_W-1:0] COST_MAX = '1;

    // Width of the reported slot field.
    localparam int PICK_SLOT_W = 2;

    typedef struct packed {
        logic accept;      // input request taken this cycle
        logic write0;      // write a first-note option
        logic scan;        // one scan step over the previous layer
        logic final_mode;  // scan compares stored costs only
        logic commit;      // close the window at its last request
        logic load;        // load the result register
    } lmtp_cmd_t;

    typedef struct packed {
        logic acc_ok;      // the offered request becomes a stored option
        logic acc_layer0;  // that option belongs to the first note
        logic acc_last;    // the offered request ends the window
        logic item_last;   // the request in work ends the window
        logic scan_last;   // scan index is at the last previous-layer option
        logic prev_empty;  // no note has been accepted
        logic out_free;    // result register can take a new result
    } lmtp_status_t;

endpackage

>>> hw/rtl/lookahead_min_travel_picker.sv
// Top level of the lookahead minimum-travel option picker.
`timescale 1ns / 1ps

// The picker takes a lookahead window as a stream of option requests, grouped
// into notes, and finds the path through the notes (one option per note) with
// the least total carriage travel from the start position. Positions are
// unsigned 1/64 mm; costs saturate at 2^19-1. When the request that ends the
// window has been processed, one result appears on the m_ channel: the option
// that the best path uses for the first note (finger, slot index, position)
// and the path cost, with ties going to the earliest option. A window with no
// accepted note returns m_pick_valid low and all other fields zero. A note
// without any reachable option ends the window early, and notes beyond
// MAX_LAYERS or options beyond MAX_OPTIONS are dropped. An accepted request
// that becomes a stored option is then either written as a first-note option
// or priced against every stored option of the previous note, since a single
// add-and-compare unit walks the previous note's options one at a time;
// s_ready stays low until that is done. The request that ends the window
// then closes the last note, runs a final minimum search over the stored
// options of the last accepted note, and loads the result register.
// The result register lets the next window start while a result still
// waits to be taken; a further result waits only if the previous one has
// not been taken yet.

module lookahead_min_travel_picker #(
    parameter int MAX_LAYERS    = 5,
    parameter int MAX_OPTIONS   = 4,
    parameter int POSITION_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_window_first,
    input  logic                              s_note_first,
    input  logic [POSITION_BITS-1:0]          s_option_position,
    input  logic [2:0]                        s_option_finger,
    input  logic                              s_option_reachable,
    input  logic                              s_window_last,
    input  logic [POSITION_BITS-1:0]          s_start_position,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_pick_valid,
    output logic [2:0]                        m_pick_finger,
    output logic [lmtp_pkg::PICK_SLOT_W-1:0]  m_pick_slot,
    output logic [POSITION_BITS-1:0]          m_pick_position,
    output logic [lmtp_pkg::COST_W-1:0]       m_total_travel
);
    import lmtp_pkg::*;

    lmtp_cmd_t    cmd;
    lmtp_status_t status;

    // The controller walks each request through accept, scan or first-note
    // write, and at the end of a window through close, final search and emit.
    lmtp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath holds the window bookkeeping, the first-note, previous and
    // current note stores, the shared scan unit and the result register. Each
    // stored option carries the index of its first-note ancestor, so the
    // result needs no walk back through the notes.
    lmtp_datapath #(
        .MAX_LAYERS    (MAX_LAYERS),
        .MAX_OPTIONS   (MAX_OPTIONS),
        .POSITION_BITS (POSITION_BITS)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .s_window_first     (s_window_first),
        .s_note_first       (s_note_first),
        .s_option_position  (s_option_position),
        .s_option_finger    (s_option_finger),
        .s_option_reachable (s_option_reachable),
        .s_window_last      (s_window_last),
        .s_start_position   (s_start_position),
        .m_ready            (m_ready),
        .m_valid            (m_valid),
        .m_pick_valid       (m_pick_valid),
        .m_pick_finger      (m_pick_finger),
        .m_pick_slot        (m_pick_slot),
        .m_pick_position    (m_pick_position),
        .m_total_travel     (m_total_travel)
    );

endmodule

>>> hw/rtl/lmtp_ctrl.sv
// Sequencing state machine of the min-travel picker.
`timescale 1ns / 1ps

module lmtp_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  lmtp_pkg::lmtp_status_t  status,
    output lmtp_pkg::lmtp_cmd_t     cmd
);
    import lmtp_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SCAN   = 6'b000010,
        ST_WRITE0 = 6'b000100,
        ST_COMMIT = 6'b001000,
        ST_FSCAN  = 6'b010000,
        ST_EMIT   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd.accept     = (state_reg == ST_IDLE) && s_valid;
        cmd.write0     = (state_reg == ST_WRITE0);
        cmd.scan       = (state_reg == ST_SCAN) ||
                         ((state_reg == ST_FSCAN) && !status.prev_empty);
        cmd.final_mode = (state_reg == ST_FSCAN);
        cmd.commit     = (state_reg == ST_COMMIT);
        cmd.load       = (state_reg == ST_EMIT) && status.out_free;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (status.acc_ok) begin
                        state_next = status.acc_layer0 ? ST_WRITE0 : ST_SCAN;
                    end else if (status.acc_last) begin
                        state_next = ST_COMMIT;
                    end
                end
            end
            ST_SCAN: begin
                if (status.scan_last) begin
                    state_next = status.item_last ? ST_COMMIT : ST_IDLE;
                end
            end
            ST_WRITE0: begin
                state_next = status.item_last ? ST_COMMIT : ST_IDLE;
            end
            ST_COMMIT: begin
                state_next = ST_FSCAN;
            end
            ST_FSCAN: begin
                if (status.prev_empty || status.scan_last) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/lmtp_datapath.sv
// Layer stores, window bookkeeping, cost scan and result register of the picker.
`timescale 1ns / 1ps

module lmtp_datapath #(
    parameter int MAX_LAYERS    = 5,
    parameter int MAX_OPTIONS   = 4,
    parameter int POSITION_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  lmtp_pkg::lmtp_cmd_t               cmd,
    output lmtp_pkg::lmtp_status_t            status,
    input  logic                              s_window_first,
    input  logic                              s_note_first,
    input  logic [POSITION_BITS-1:0]          s_option_position,
    input  logic [2:0]                        s_option_finger,
    input  logic                              s_option_reachable,
    input  logic                              s_window_last,
    input  logic [POSITION_BITS-1:0]          s_start_position,
    input  logic                              m_ready,
    output logic                              m_valid,
    output logic                              m_pick_valid,
    output logic [2:0]                        m_pick_finger,
    output logic [lmtp_pkg::PICK_SLOT_W-1:0]  m_pick_slot,
    output logic [POSITION_BITS-1:0]          m_pick_position,
    output logic [lmtp_pkg::COST_W-1:0]       m_total_travel
);
    import lmtp_pkg::*;

    localparam int SLOT_W = (MAX_OPTIONS > 1) ? $clog2(MAX_OPTIONS) : 1;
    localparam int CNT_W  = $clog2(MAX_OPTIONS + 1);
    localparam int LAY_W  = $clog2(MAX_LAYERS + 1);
    localparam int SUM_W  = ((COST_W > POSITION_BITS) ? COST_W : POSITION_BITS) + 1;
    localparam int SLOT_EXT_W = (SLOT_W > PICK_SLOT_W) ? SLOT_W : PICK_SLOT_W;

    function automatic logic [POSITION_BITS-1:0] pos_dist(
        input logic [POSITION_BITS-1:0] a,
        input logic [POSITION_BITS-1:0] b
    );
        logic [POSITION_BITS-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d;
    endfunction

    function automatic logic [COST_W-1:0] sat_cost(input logic [SUM_W-1:0] v);
        logic [COST_W-1:0] r;
        r = (v > SUM_W'(COST_MAX)) ? COST_MAX : v[COST_W-1:0];
        return r;
    endfunction

    // Window bookkeeping.
    logic [POSITION_BITS-1:0] origin_reg, origin_next;
    logic [CNT_W-1:0]         cnt0_reg, cnt0_next;
    logic [CNT_W-1:0]         cnt1_reg, cnt1_next;
    logic [CNT_W-1:0]         slot_reg, slot_next;
    logic [LAY_W-1:0]         layers_reg, layers_next;
    logic                     closed_reg, closed_next;
    logic                     open_reg, open_next;
    logic                     copy_en;

    // Bookkeeping as it stands after the offered request.
    logic [POSITION_BITS-1:0] pre_origin;
    logic [CNT_W-1:0]         pre_cnt0, pre_cnt1, pre_slot, acc_slot, acc_c;
    logic [LAY_W-1:0]         pre_layers;
    logic                     pre_closed, pre_open, pre_copy;
    logic                     acc_ok, acc_layer0;

    // Option stores.
    logic [POSITION_BITS-1:0] first_pos_reg    [MAX_OPTIONS];
    logic [2:0]               first_finger_reg [MAX_OPTIONS];
    logic [SLOT_W-1:0]        first_slot_reg   [MAX_OPTIONS];
    logic [POSITION_BITS-1:0] prev_pos_reg     [MAX_OPTIONS];
    logic [COST_W-1:0]        prev_cost_reg    [MAX_OPTIONS];
    logic [SLOT_W-1:0]        prev_root_reg    [MAX_OPTIONS];
    logic [POSITION_BITS-1:0] cur_pos_reg      [MAX_OPTIONS];
    logic [COST_W-1:0]        cur_cost_reg     [MAX_OPTIONS];
    logic [SLOT_W-1:0]        cur_root_reg     [MAX_OPTIONS];

    // Request in work.
    logic [POSITION_BITS-1:0] item_pos_reg;
    logic [2:0]               item_finger_reg;
    logic [SLOT_W-1:0]        item_slot_reg;
    logic [SLOT_W-1:0]        item_c_reg;
    logic                     item_last_reg;

    // Scan unit.
    logic [SLOT_W-1:0]        k_reg;
    logic [COST_W-1:0]        best_reg;
    logic [SLOT_W-1:0]        root_reg;
    logic [POSITION_BITS-1:0] sel_pos;
    logic [COST_W-1:0]        sel_cost;
    logic [SLOT_W-1:0]        sel_root;
    logic [SUM_W-1:0]         scan_sum;
    logic [COST_W-1:0]        scan_cand, scan_best;
    logic [SLOT_W-1:0]        scan_root;
    logic                     scan_take, scan_last;
    logic                     scan_write;
    logic [COST_W-1:0]        first_cost;
    logic                     prev_empty;

    // Result register.
    logic                     m_valid_reg;
    logic                     pick_valid_reg;
    logic [2:0]               pick_finger_reg;
    logic [PICK_SLOT_W-1:0]   pick_slot_reg;
    logic [POSITION_BITS-1:0] pick_position_reg;
    logic [COST_W-1:0]        total_travel_reg;
    logic [SLOT_EXT_W-1:0]    slot_ext;

    // Window start, note close and note open for the offered request.
    always_comb begin
        logic nf;
        nf         = s_note_first;
        pre_origin = origin_reg;
        pre_cnt0   = cnt0_reg;
        pre_cnt1   = cnt1_reg;
        pre_slot   = slot_reg;
        pre_layers = layers_reg;
        pre_closed = closed_reg;
        pre_open   = open_reg;
        pre_copy   = 1'b0;
        acc_slot   = slot_reg;
        acc_c      = cnt1_reg;
        acc_ok     = 1'b0;
        acc_layer0 = 1'b0;
        if (s_window_first) begin
            pre_origin = s_start_position;
            pre_cnt0   = '0;
            pre_cnt1   = '0;
            pre_slot   = '0;
            pre_layers = '0;
            pre_closed = 1'b0;
            pre_open   = 1'b0;
            nf         = 1'b1;
        end
        if (nf) begin
            if (pre_open && !pre_closed) begin
                if (pre_cnt1 == '0) begin
                    // A note without a reachable option ends the window.
                    pre_closed = 1'b1;
                end else begin
                    pre_copy   = 1'b1;
                    pre_cnt0   = pre_cnt1;
                    pre_cnt1   = '0;
                    pre_layers = pre_layers + 1'b1;
                    if (pre_layers >= LAY_W'(MAX_LAYERS)) begin
                        pre_closed = 1'b1;
                    end
                end
            end
            pre_open = 1'b0;
            if (!pre_closed) begin
                pre_open = 1'b1;
                pre_slot = '0;
                pre_cnt1 = '0;
            end
        end else if (!pre_open && !pre_closed) begin
            pre_open = 1'b1;
            pre_slot = '0;
            pre_cnt1 = '0;
        end
        if (!pre_closed) begin
            acc_slot = pre_slot;
            acc_c    = pre_cnt1;
            if (pre_slot < CNT_W'(MAX_OPTIONS)) begin
                pre_slot = pre_slot + 1'b1;
            end
            acc_ok = (acc_slot < CNT_W'(MAX_OPTIONS)) && s_option_reachable &&
                     (acc_c < CNT_W'(MAX_OPTIONS));
            acc_layer0 = (pre_layers == '0);
        end
    end

    // Scan step: cost through previous-layer option k, earliest wins ties.
    always_comb begin
        sel_pos   = prev_pos_reg[k_reg];
        sel_cost  = prev_cost_reg[k_reg];
        sel_root  = prev_root_reg[k_reg];
        scan_sum  = SUM_W'(sel_cost);
        if (!cmd.final_mode) begin
            scan_sum = SUM_W'(sel_cost) + SUM_W'(pos_dist(item_pos_reg, sel_pos));
        end
        scan_cand = sat_cost(scan_sum);
        scan_take = (k_reg == '0) || (scan_cand < best_reg);
        scan_best = scan_take ? scan_cand : best_reg;
        scan_root = scan_take ? sel_root : root_reg;
        scan_last = ((CNT_W'(k_reg) + CNT_W'(1)) == cnt0_reg);
    end

    assign scan_write = cmd.scan && !cmd.final_mode && scan_last;
    assign first_cost = sat_cost(SUM_W'(pos_dist(item_pos_reg, origin_reg)));
    assign prev_empty = (cnt0_reg == '0) || (layers_reg == '0);

    // Bookkeeping updates.
    always_comb begin
        origin_next = origin_reg;
        cnt0_next   = cnt0_reg;
        cnt1_next   = cnt1_reg;
        slot_next   = slot_reg;
        layers_next = layers_reg;
        closed_next = closed_reg;
        open_next   = open_reg;
        copy_en     = 1'b0;
        if (cmd.accept) begin
            origin_next = pre_origin;
            cnt0_next   = pre_cnt0;
            cnt1_next   = pre_cnt1;
            slot_next   = pre_slot;
            layers_next = pre_layers;
            closed_next = pre_closed;
            open_next   = pre_open;
            copy_en     = pre_copy;
        end
        if (cmd.write0 || scan_write) begin
            cnt1_next = cnt1_reg + 1'b1;
        end
        if (cmd.commit) begin
            if (open_reg && !closed_reg && (cnt1_reg != '0)) begin
                copy_en     = 1'b1;
                cnt0_next   = cnt1_reg;
                cnt1_next   = '0;
                layers_next = layers_reg + 1'b1;
            end
            open_next   = 1'b0;
            closed_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_reg    <= '0;
            cnt0_reg      <= '0;
            cnt1_reg      <= '0;
            slot_reg      <= '0;
            layers_reg    <= '0;
            closed_reg    <= 1'b0;
            open_reg      <= 1'b0;
            item_last_reg <= 1'b0;
            k_reg         <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            origin_reg <= origin_next;
            cnt0_reg   <= cnt0_next;
            cnt1_reg   <= cnt1_next;
            slot_reg   <= slot_next;
            layers_reg <= layers_next;
            closed_reg <= closed_next;
            open_reg   <= open_next;
            if (cmd.accept) begin
                item_last_reg <= s_window_last;
                k_reg         <= '0;
            end else if (cmd.scan) begin
                k_reg <= scan_last ? '0 : (k_reg + 1'b1);
            end
            if (cmd.load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_pos_reg    <= s_option_position;
            item_finger_reg <= s_option_finger;
            item_slot_reg   <= SLOT_W'(acc_slot);
            item_c_reg      <= SLOT_W'(acc_c);
        end
        if (cmd.scan) begin
            best_reg <= scan_best;
            root_reg <= scan_root;
        end
        if (copy_en) begin
            for (int i = 0; i < MAX_OPTIONS; i++) begin
                prev_pos_reg[i]  <= cur_pos_reg[i];
                prev_cost_reg[i] <= cur_cost_reg[i];
                prev_root_reg[i] <= cur_root_reg[i];
            end
        end
        if (cmd.write0) begin
            cur_pos_reg[item_c_reg]      <= item_pos_reg;
            cur_cost_reg[item_c_reg]     <= first_cost;
            cur_root_reg[item_c_reg]     <= item_c_reg;
            first_pos_reg[item_c_reg]    <= item_pos_reg;
            first_finger_reg[item_c_reg] <= item_finger_reg;
            first_slot_reg[item_c_reg]   <= item_slot_reg;
        end else if (scan_write) begin
            cur_pos_reg[item_c_reg]  <= item_pos_reg;
            cur_cost_reg[item_c_reg] <= scan_best;
            cur_root_reg[item_c_reg] <= scan_root;
        end
    end

    assign slot_ext = SLOT_EXT_W'(first_slot_reg[root_reg]);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            if (prev_empty) begin
                pick_valid_reg    <= 1'b0;
                pick_finger_reg   <= '0;
                pick_slot_reg     <= '0;
                pick_position_reg <= '0;
                total_travel_reg  <= '0;
            end else begin
                pick_valid_reg    <= 1'b1;
                pick_finger_reg   <= first_finger_reg[root_reg];
                pick_slot_reg     <= slot_ext[PICK_SLOT_W-1:0];
                pick_position_reg <= first_pos_reg[root_reg];
                total_travel_reg  <= best_reg;
            end
        end
    end

    always_comb begin
        status.acc_ok     = acc_ok;
        status.acc_layer0 = acc_layer0;
        status.acc_last   = s_window_last;
        status.item_last  = item_last_reg;
        status.scan_last  = scan_last;
        status.prev_empty = prev_empty;
        status.out_free   = !m_valid_reg || m_ready;
    end

    assign m_valid         = m_valid_reg;
    assign m_pick_valid    = pick_valid_reg;
    assign m_pick_finger   = pick_finger_reg;
    assign m_pick_slot     = pick_slot_reg;
    assign m_pick_position = pick_position_reg;
    assign m_total_travel  = total_travel_reg;

endmodule

>>> sim/lookahead_min_travel_picker_tb.sv
// Self-checking testbench for the lookahead minimum-travel option picker.
`timescale 1ns / 1ps

// The testbench feeds option requests through the s_ channel and checks every
// pick that appears on the m_ channel against a predictor kept in this module.
// The predictor follows the picker's layered search. Each stored option carries
// its cost and the index of its first-note ancestor, and the window's pick is the
// cheapest option of the last accepted note. The first edge wins every tie.
// A clocked driver pops requests from a queue that the stimulus block fills
// before reset is released. A clocked monitor checks each pick against the
// oldest pending one. Both sides idle at random, except for a calm stretch in
// the middle of the run.

module lookahead_min_travel_picker_tb;

    localparam int MAX_LAYERS    = 5;
    localparam int MAX_OPTIONS   = 4;
    localparam int POS_W         = 16;
    localparam int COST_W        = lmtp_pkg::COST_W;
    localparam int SLOT_W        = lmtp_pkg::PICK_SLOT_W;
    localparam int RANDOM_ITEMS  = 800;
    localparam int IDLE_PCT      = 25;
    localparam int CALM_FROM     = 300;
    localparam int CALM_TO       = 450;
    localparam int SETTLE_CYCLES = 40;

    // One option request as the driver presents it. The drain bit is not a port:
    // it holds the request back until every pending pick has been taken.
    typedef struct packed {
        logic             window_first;
        logic             note_first;
        logic [POS_W-1:0] option_position;
        logic [2:0]       option_finger;
        logic             option_reachable;
        logic             window_last;
        logic [POS_W-1:0] start_position;
        logic             drain;
    } option_req_t;

    typedef struct packed {
        logic              pick_valid;
        logic [2:0]        pick_finger;
        logic [SLOT_W-1:0] pick_slot;
        logic [POS_W-1:0]  pick_position;
        logic [COST_W-1:0] total_travel;
    } pick_t;

    logic              aclk               = 1'b0;
    logic              aresetn            = 1'b0;
    logic              s_valid            = 1'b0;
    logic              s_ready;
    logic              s_window_first     = 1'b0;
    logic              s_note_first       = 1'b0;
    logic [POS_W-1:0]  s_option_position  = '0;
    logic [2:0]        s_option_finger    = '0;
    logic              s_option_reachable = 1'b0;
    logic              s_window_last      = 1'b0;
    logic [POS_W-1:0]  s_start_position   = '0;
    logic              m_valid;
    logic              m_ready            = 1'b0;
    logic              m_pick_valid;
    logic [2:0]        m_pick_finger;
    logic [SLOT_W-1:0] m_pick_slot;
    logic [POS_W-1:0]  m_pick_position;
    logic [COST_W-1:0] m_total_travel;

    lookahead_min_travel_picker #(
        .MAX_LAYERS    (MAX_LAYERS),
        .MAX_OPTIONS   (MAX_OPTIONS),
        .POSITION_BITS (POS_W)
    ) u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_window_first     (s_window_first),
        .s_note_first       (s_note_first),
        .s_option_position  (s_option_position),
        .s_option_finger    (s_option_finger),
        .s_option_reachable (s_option_reachable),
        .s_window_last      (s_window_last),
        .s_start_position   (s_start_position),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_pick_valid       (m_pick_valid),
        .m_pick_finger      (m_pick_finger),
        .m_pick_slot        (m_pick_slot),
        .m_pick_position    (m_pick_position),
        .m_total_travel     (m_total_travel)
    );

    always #5 aclk = ~aclk;

    option_req_t request_q[$];
    pick_t       pick_q[$];
    option_req_t held_req;
    int          requests_total    = 0;
    int          requests_accepted = 0;
    int          mismatch_count    = 0;

    // Predictor state. The "prior" arrays hold the last accepted note and the
    // "open" arrays hold the note that is being collected. Before any window
    // the origin is zero.
    logic [POS_W-1:0]  origin_pos = '0;
    logic [POS_W-1:0]  first_pos[MAX_OPTIONS];
    logic [2:0]        first_finger[MAX_OPTIONS];
    logic [SLOT_W-1:0] first_slot[MAX_OPTIONS];
    logic [POS_W-1:0]  prior_pos[MAX_OPTIONS];
    logic [COST_W-1:0] prior_cost[MAX_OPTIONS];
    logic [SLOT_W-1:0] prior_root[MAX_OPTIONS];
    logic [POS_W-1:0]  open_pos[MAX_OPTIONS];
    logic [COST_W-1:0] open_cost[MAX_OPTIONS];
    logic [SLOT_W-1:0] open_root[MAX_OPTIONS];
    int                prior_count  = 0;
    int                open_count   = 0;
    int                slot_ctr     = 0;
    int                notes_taken  = 0;
    bit                window_shut  = 1'b0;
    bit                note_open    = 1'b0;

    // The calm stretch keeps both sides busy on every cycle.
    wire calm = (requests_accepted >= CALM_FROM) && (requests_accepted < CALM_TO);

    function automatic logic [POS_W-1:0] travel_between(input logic [POS_W-1:0] a,
                                                        input logic [POS_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Ends the note that is being collected. A note with no usable option ends
    // the whole window, and the window also ends after MAX_LAYERS notes.
    task automatic close_note();
        if (!note_open || window_shut) begin
            note_open = 1'b0;
        end else begin
            note_open = 1'b0;
            if (open_count == 0) begin
                window_shut = 1'b1;
            end else begin
                prior_pos   = open_pos;
                prior_cost  = open_cost;
                prior_root  = open_root;
                prior_count = open_count;
                open_count  = 0;
                notes_taken++;
                if (notes_taken >= MAX_LAYERS)
                    window_shut = 1'b1;
            end
        end
    endtask

    // Applies one accepted request to the predictor. If the request ends the
    // window, the pick that it causes is appended to pick_q.
    task automatic track_request(input option_req_t r);
        logic                new_note;
        int                  slot;
        int                  c;
        int                  k;
        logic [COST_W-1:0]   best;
        logic [COST_W-1:0]   cost;
        logic [COST_W:0]     sum;
        logic [SLOT_W-1:0]   root;
        pick_t               pick;
        new_note = r.note_first;
        if (r.window_first) begin
            origin_pos  = r.start_position;
            prior_count = 0;
            open_count  = 0;
            slot_ctr    = 0;
            notes_taken = 0;
            window_shut = 1'b0;
            note_open   = 1'b0;
            new_note    = 1'b1;
        end
        if (new_note) begin
            close_note();
            if (!window_shut) begin
                note_open  = 1'b1;
                slot_ctr   = 0;
                open_count = 0;
            end
        end else if (!note_open && !window_shut) begin
            // A note is opened even when note_first is missing.
            note_open  = 1'b1;
            slot_ctr   = 0;
            open_count = 0;
        end

        if (!window_shut) begin
            slot = slot_ctr;
            if (slot_ctr < MAX_OPTIONS)
                slot_ctr++;
            if (slot < MAX_OPTIONS && r.option_reachable && open_count < MAX_OPTIONS) begin
                c = open_count;
                if (notes_taken == 0) begin
                    // First-note options start at the origin and are their own root.
                    best            = COST_W'(travel_between(r.option_position, origin_pos));
                    root            = SLOT_W'(c);
                    first_pos[c]    = r.option_position;
                    first_finger[c] = r.option_finger;
                    first_slot[c]   = SLOT_W'(slot);
                end else begin
                    best = lmtp_pkg::COST_MAX;
                    root = '0;
                    for (k = 0; k < prior_count; k++) begin
                        sum = {1'b0, prior_cost[k]}
                            + (COST_W + 1)'(travel_between(r.option_position, prior_pos[k]));
                        cost = (sum > lmtp_pkg::COST_MAX) ? lmtp_pkg::COST_MAX : sum[COST_W-1:0];
                        // A later edge takes over only when it is strictly cheaper.
                        if (k == 0 || cost < best) begin
                            best = cost;
                            root = prior_root[k];
                        end
                    end
                end
                open_pos[c]  = r.option_position;
                open_cost[c] = best;
                open_root[c] = root;
                open_count   = c + 1;
            end
        end

        if (r.window_last) begin
            close_note();
            window_shut = 1'b1;
            pick = '0;
            if (notes_taken != 0 && prior_count != 0) begin
                best = prior_cost[0];
                root = prior_root[0];
                for (k = 1; k < prior_count; k++) begin
                    if (prior_cost[k] < best) begin
                        best = prior_cost[k];
                        root = prior_root[k];
                    end
                end
                pick.pick_valid    = 1'b1;
                pick.pick_finger   = first_finger[root];
                pick.pick_slot     = first_slot[root];
                pick.pick_position = first_pos[root];
                pick.total_travel  = best;
            end
            pick_q.push_back(pick);
        end
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic queue_request(input bit wf, input bit nf, input int unsigned pos,
                                 input int unsigned finger, input bit reach, input bit wl,
                                 input int unsigned origin, input bit drain);
        option_req_t r;
        r.window_first     = wf;
        r.note_first       = nf;
        r.option_position  = POS_W'(pos);
        r.option_finger    = 3'(finger);
        r.option_reachable = reach;
        r.window_last      = wl;
        r.start_position   = POS_W'(origin);
        r.drain            = drain;
        request_q.push_back(r);
    endtask

    // Driver. A request is tracked by the predictor at the edge where it is
    // accepted. A new request is offered only when no request is held.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                track_request(held_req);
                requests_accepted++;
            end
            if (!(s_valid && !s_ready)) begin
                if (request_q.size() != 0 && !(request_q[0].drain && pick_q.size() != 0)
                    && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    held_req            = request_q.pop_front();
                    s_valid            <= 1'b1;
                    s_window_first     <= held_req.window_first;
                    s_note_first       <= held_req.note_first;
                    s_option_position  <= held_req.option_position;
                    s_option_finger    <= held_req.option_finger;
                    s_option_reachable <= held_req.option_reachable;
                    s_window_last      <= held_req.window_last;
                    s_start_position   <= held_req.start_position;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Each pick taken from the picker is compared with the oldest one
    // that is pending. m_ready stalls at random outside the calm stretch.
    always @(posedge aclk) begin
        pick_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pick_q.size() == 0) begin
                    $display({"%0t: unexpected pick, expected none, got valid=%0d ",
                              "finger=%0d slot=%0d pos=%0d travel=%0d"},
                             $time, m_pick_valid, m_pick_finger, m_pick_slot,
                             m_pick_position, m_total_travel);
                    mismatch_count++;
                end else begin
                    want = pick_q.pop_front();
                    check_field("pick_valid", want.pick_valid, m_pick_valid);
                    check_field("pick_finger", want.pick_finger, m_pick_finger);
                    check_field("pick_slot", want.pick_slot, m_pick_slot);
                    check_field("pick_position", want.pick_position, m_pick_position);
                    check_field("total_travel", want.total_travel, m_total_travel);
                end
            end
            m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int          random_items;
        int          windows_made;
        int          notes;
        int          opts;
        int          kind;
        int          n;
        int          o;
        bit          spread;
        bit          skip_first;
        bit          drop_last;
        bit          dead_note;
        bit          wf;
        bit          nf;
        bit          wl;
        logic [POS_W-1:0] origin;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] last_pos;

        // Before any window the picker behaves as if a window were open with
        // origin zero. A second window_last repeats the same pick.
        queue_request(0, 1, 100, 3, 1, 0, 0, 0);
        queue_request(0, 0, 65535, 5, 1, 0, 0, 0);
        queue_request(0, 1, 50, 1, 1, 1, 0, 0);
        queue_request(0, 0, 7, 7, 1, 1, 0, 0);
        // The first note has no reachable option, so the pick is empty. The
        // window_first request carries no note_first.
        queue_request(1, 0, 1234, 2, 0, 1, 999, 0);
        // Full-scale positions, an unreachable slot, a fifth option that is
        // dropped, and a sixth note that is dropped.
        queue_request(1, 0, 0, 7, 1, 0, 65535, 0);
        queue_request(0, 0, 65535, 0, 1, 0, 0, 0);
        queue_request(0, 0, 32768, 4, 0, 0, 0, 0);
        queue_request(0, 0, 1, 6, 1, 0, 0, 0);
        queue_request(0, 0, 65535, 1, 1, 0, 0, 0);
        queue_request(0, 1, 0, 0, 1, 0, 0, 0);
        queue_request(0, 1, 65535, 2, 1, 0, 0, 0);
        queue_request(0, 1, 0, 3, 1, 0, 0, 0);
        queue_request(0, 1, 65535, 4, 1, 0, 0, 0);
        queue_request(0, 1, 0, 5, 1, 1, 0, 0);
        // A tie on the first note goes to the first option. A dead note in
        // the middle ends the window.
        queue_request(1, 1, 900, 2, 1, 0, 1000, 0);
        queue_request(0, 0, 1100, 3, 1, 0, 0, 0);
        queue_request(0, 1, 5000, 4, 0, 0, 0, 0);
        queue_request(0, 1, 1000, 5, 1, 1, 0, 0);
        // Largest possible travel: five full-scale swings. The sender first
        // waits until every pending pick has been taken.
        queue_request(1, 1, 65535, 7, 1, 0, 0, 1);
        queue_request(0, 1, 0, 6, 1, 0, 0, 0);
        queue_request(0, 1, 65535, 5, 1, 0, 0, 0);
        queue_request(0, 1, 0, 4, 1, 0, 0, 0);
        queue_request(0, 1, 65535, 3, 1, 1, 0, 0);

        // Most random traffic is well-formed windows. The rest is noise, windows
        // without window_first, and windows that lack window_last.
        random_items = 0;
        windows_made = 0;
        while (random_items < RANDOM_ITEMS) begin
            kind = $urandom_range(99);
            if (kind < 8) begin
                queue_request($urandom_range(3) == 0, $urandom_range(1), $urandom,
                              $urandom_range(7), $urandom_range(1), $urandom_range(3) == 0,
                              $urandom, 0);
                random_items++;
            end else begin
                notes      = ($urandom_range(9) == 0) ? $urandom_range(6, 7) : $urandom_range(1, 5);
                origin     = POS_W'($urandom);
                spread     = $urandom_range(1);
                skip_first = (kind < 12);
                drop_last  = (kind >= 12 && kind < 15);
                last_pos   = origin;
                for (n = 0; n < notes; n++) begin
                    opts      = ($urandom_range(7) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
                    dead_note = ($urandom_range(19) == 0);
                    for (o = 0; o < opts; o++) begin
                        // Narrow windows keep costs close, so ties and near-ties
                        // show up often. Repeated positions force exact ties.
                        if ($urandom_range(7) == 0)
                            pos = last_pos;
                        else if (spread)
                            pos = origin + POS_W'($urandom_range(64)) - POS_W'(32);
                        else
                            pos = POS_W'($urandom);
                        last_pos = pos;
                        wf = (n == 0 && o == 0 && !skip_first);
                        nf = (o == 0) && !(wf && $urandom_range(3) == 0);
                        wl = (n == notes - 1 && o == opts - 1 && !drop_last);
                        queue_request(wf, nf, pos, $urandom_range(7),
                                      !dead_note && ($urandom_range(99) < 85), wl, origin,
                                      wf && (windows_made == 6 || $urandom_range(29) == 0));
                        random_items++;
                    end
                end
                windows_made++;
            end
        end
        requests_total = request_q.size();

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (requests_accepted != requests_total)
            @(posedge aclk);
        while (pick_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("lookahead_min_travel_picker_tb: done, clean");
        end else begin
            $display("lookahead_min_travel_picker_tb: done, errors");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("%0t: timeout", $time);
        $display("lookahead_min_travel_picker_tb: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/lmtp_pkg.sv
hw/rtl/lmtp_ctrl.sv
hw/rtl/lmtp_datapath.sv
hw/rtl/lookahead_min_travel_picker.sv
sim/lookahead_min_travel_picker_tb.sv
